// ===== rtl/rtdct_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdct_pkg: shared types and constants for the RTD code to temperature block
// Holds the field widths, register indexes, status codes and the work records
// that travel along the divider and square root cell chains.
// ----------------------------------------------------------------------------
package rtdct_pkg;

  // Converter code width.
  localparam int CODE_BITS = 15;

  // Probe resistance product and the signed excess over the nominal value.
  localparam int N_W    = CODE_BITS + 16;
  localparam int DIFF_W = ((N_W > 31) ? N_W : 31) + 1;
  localparam int MAG_W  = DIFF_W - 1;
  // Numerator of the relative excess division (magnitude times 2^9).
  localparam int NUM1_W = MAG_W + 9;

  // Shared restoring divider cell geometry.
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 33;

  // Square root cell geometry: 64-bit radicand, 32-bit root.
  localparam int SQ_RAD_W = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_REM_W  = 33;

  // Chain lengths.
  localparam int DIV1_CELLS = NUM1_W;
  localparam int SQRT_CELLS = SQ_ROOT_W;
  localparam int DIV2_CELLS = DIV_NUM_W;

  // Field widths.
  localparam int TEMP_W = 19;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;
  localparam int DQ_W   = 32;

  // Scale factors of the final division.
  localparam int K_POS = 409600;
  localparam int K_NEG = 25600;

  // Output limits.
  localparam int T_MIN = -100000;
  localparam int T_MAX = 200000;

  // Register indexes.
  localparam logic [IDX_W-1:0] CFG_REF_RES   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_NOM_RES   = 3'd1;
  localparam logic [IDX_W-1:0] CFG_COEF_A    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_COEF_B    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_VALID_LO  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_VALID_HI  = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_WINDOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOROOT = 2'd2;

  // Partial state of one restoring division step.
  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_DEN_W-1:0] den;
  } div_work_t;

  // Partial state of one square root step.
  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_REM_W-1:0]  rem;
  } sqrt_work_t;

  // Side information that rides along with each transaction.
  typedef struct packed {
    logic            nomz;
    logic            neg;
    logic            negdisc;
    logic            dq_zero;
    logic            posinf;
    logic            neginf;
    logic [DQ_W-1:0] dq;
  } ctx_t;

endpackage

// ===== rtl/rtdct_div_cell.sv =====
// ----------------------------------------------------------------------------
// rtdct_div_cell: one step of a restoring divider
// Shifts one numerator bit into the partial remainder, produces one quotient
// bit and registers the result for the next cell of the chain.
// ----------------------------------------------------------------------------
module rtdct_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  rtdct_pkg::div_work_t  in_work,
  input  rtdct_pkg::ctx_t       in_ctx,
  output logic                  out_valid_r,
  output rtdct_pkg::div_work_t  out_work_r,
  output rtdct_pkg::ctx_t       out_ctx_r
);
  import rtdct_pkg::*;

  logic [DIV_DEN_W:0] shifted;
  logic [DIV_DEN_W:0] diff;
  logic               take;
  div_work_t          work_nxt;

  always_comb begin
    shifted       = {in_work.rem, in_work.num[DIV_NUM_W-1]};
    diff          = shifted - {1'b0, in_work.den};
    take          = (shifted >= {1'b0, in_work.den});
    work_nxt.den  = in_work.den;
    work_nxt.num  = {in_work.num[DIV_NUM_W-2:0], 1'b0};
    work_nxt.quo  = {in_work.quo[DIV_NUM_W-2:0], take};
    work_nxt.rem  = take ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work_r <= work_nxt;
      out_ctx_r  <= in_ctx;
    end
  end

endmodule

// ===== rtl/rtdct_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rtdct_sqrt_cell: one step of a restoring integer square root
// Brings down two radicand bits, tries the next root bit and registers the
// partial root and remainder for the next cell of the chain.
// ----------------------------------------------------------------------------
module rtdct_sqrt_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  rtdct_pkg::sqrt_work_t  in_work,
  input  rtdct_pkg::ctx_t        in_ctx,
  output logic                   out_valid_r,
  output rtdct_pkg::sqrt_work_t  out_work_r,
  output rtdct_pkg::ctx_t        out_ctx_r
);
  import rtdct_pkg::*;

  logic [SQ_REM_W+1:0] shifted;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                take;
  sqrt_work_t          work_nxt;

  always_comb begin
    shifted       = {in_work.rem, in_work.rad[SQ_RAD_W-1 -: 2]};
    trial         = {1'b0, in_work.root, 2'b01};
    diff          = shifted - trial;
    take          = (shifted >= trial);
    work_nxt.rad  = {in_work.rad[SQ_RAD_W-3:0], 2'b00};
    work_nxt.root = {in_work.root[SQ_ROOT_W-2:0], take};
    work_nxt.rem  = take ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work_r <= work_nxt;
      out_ctx_r  <= in_ctx;
    end
  end

endmodule

// ===== rtl/rtd_code_to_temperature.sv =====
// ----------------------------------------------------------------------------
// rtd_code_to_temperature: RTD converter code to temperature, inverse CVD
// Most of the pipeline length comes from the three bit-per-cell chains.
// Throughput is one transaction per cycle while the result side keeps up.
// Synchronous active-low reset clears all valid flags and loads the
// documented register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rtdct_pkg::CODE_BITS-1:0]     in_rtd_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rtdct_pkg::TEMP_W-1:0] out_temperature,
  output logic [rtdct_pkg::STAT_W-1:0]        out_status,
  input  logic                                cfg_we,
  input  logic [rtdct_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rtdct_pkg::CFG_W-1:0]         cfg_wdata
);
  import rtdct_pkg::*;

  localparam int RAW_W = DIV_NUM_W + 2;
  localparam logic signed [RAW_W-1:0]  RAW_MIN  = RAW_W'(T_MIN);
  localparam logic signed [RAW_W-1:0]  RAW_MAX  = RAW_W'(T_MAX);
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = TEMP_W'(T_MIN);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = TEMP_W'(T_MAX);
  localparam logic [DQ_W-1:0]          DQ_MAX   = {1'b0, {(DQ_W-1){1'b1}}};

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce this. Every stage reads them directly.
  logic [15:0]              ref_res_r;
  logic [15:0]              nom_res_r;
  logic [25:0]              coef_a_r;
  logic signed [31:0]       coef_b_r;
  logic signed [TEMP_W-1:0] valid_lo_r;
  logic signed [TEMP_W-1:0] valid_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_res_r  <= 16'd3440;
      nom_res_r  <= 16'd800;
      coef_a_r   <= 26'd16786021;
      coef_b_r   <= -32'sd162551799;
      valid_lo_r <= TEMP_W'(-20000);
      valid_hi_r <= TEMP_W'(85000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_RES:  ref_res_r  <= cfg_wdata[15:0];
        CFG_NOM_RES:  nom_res_r  <= cfg_wdata[15:0];
        CFG_COEF_A:   coef_a_r   <= cfg_wdata[25:0];
        CFG_COEF_B:   coef_b_r   <= cfg_wdata[31:0];
        CFG_VALID_LO: valid_lo_r <= cfg_wdata[TEMP_W-1:0];
        CFG_VALID_HI: valid_hi_r <= cfg_wdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together. It holds only while a finished result
  // sits in the output register and the receiver stalls it. The input stage
  // can still take one transaction during such a hold when it is empty.
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  logic s0_valid_r;
  assign in_stall = s0_valid_r && !en;

  // Stage 0: input register.
  logic [CODE_BITS-1:0] s0_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_code_r <= in_rtd_code;
    end
  end

  // Stage 1: probe resistance numerator, code times reference resistance.
  logic           s1_valid_r;
  logic [N_W-1:0] s1_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_n_r <= N_W'(s0_code_r) * N_W'(ref_res_r);
    end
  end

  // Stage 2: signed excess over the nominal resistance. Its magnitude times
  // 2^9 over the nominal resistance is the relative excess in Q.24, since the
  // common factor 2^15 of the nominal term cancels.
  logic signed [DIFF_W-1:0] s2_diff;
  logic [MAG_W-1:0]         s2_mag;
  div_work_t                s2_work;
  ctx_t                     s2_ctx;
  logic                     s2_valid_r;
  div_work_t                s2_work_r;
  ctx_t                     s2_ctx_r;

  always_comb begin
    s2_diff        = $signed(DIFF_W'(s1_n_r)) - $signed(DIFF_W'({nom_res_r, 15'd0}));
    s2_mag         = s2_diff[DIFF_W-1] ? MAG_W'(-s2_diff) : MAG_W'(s2_diff);
    s2_work.num    = DIV_NUM_W'({s2_mag, 9'd0}) << (DIV_NUM_W - NUM1_W);
    s2_work.quo    = '0;
    s2_work.rem    = '0;
    s2_work.den    = DIV_DEN_W'(nom_res_r);
    s2_ctx.nomz    = (nom_res_r == 16'd0);
    s2_ctx.neg     = s2_diff[DIFF_W-1];
    s2_ctx.negdisc = 1'b0;
    s2_ctx.dq_zero = 1'b0;
    s2_ctx.posinf  = 1'b0;
    s2_ctx.neginf  = 1'b0;
    s2_ctx.dq      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_work_r <= s2_work;
      s2_ctx_r  <= s2_ctx;
    end
  end

  // First divider chain: one quotient bit per cell.
  logic [DIV1_CELLS:0] d1_v;
  div_work_t           d1_w [DIV1_CELLS+1];
  ctx_t                d1_c [DIV1_CELLS+1];

  assign d1_v[0] = s2_valid_r;
  assign d1_w[0] = s2_work_r;
  assign d1_c[0] = s2_ctx_r;

  for (genvar i = 0; i < DIV1_CELLS; i++) begin : g_div1
    rtdct_div_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (d1_v[i]),
      .in_work     (d1_w[i]),
      .in_ctx      (d1_c[i]),
      .out_valid_r (d1_v[i+1]),
      .out_work_r  (d1_w[i+1]),
      .out_ctx_r   (d1_c[i+1])
    );
  end

  // Stage 3: signed Q.24 excess, saturated on the positive side. The
  // negative side is bounded by minus one, so no saturation is needed there.
  logic [NUM1_W-1:0] s3_q;
  ctx_t              s3_ctx;
  logic              s3_valid_r;
  ctx_t              s3_ctx_r;

  always_comb begin
    s3_q   = d1_w[DIV1_CELLS].quo[NUM1_W-1:0];
    s3_ctx = d1_c[DIV1_CELLS];
    if (s3_ctx.neg) begin
      s3_ctx.dq = DQ_W'(~s3_q + NUM1_W'(1));
    end else if (s3_q > NUM1_W'(DQ_MAX)) begin
      s3_ctx.dq = DQ_MAX;
    end else begin
      s3_ctx.dq = DQ_W'(s3_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= d1_v[DIV1_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctx_r <= s3_ctx;
    end
  end

  // Stage 4: the two products of the discriminant.
  logic               s4_valid_r;
  logic [51:0]        s4_aa_r;
  logic signed [63:0] s4_bd_r;
  ctx_t               s4_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_aa_r  <= 52'(coef_a_r) * 52'(coef_a_r);
      s4_bd_r  <= $signed({{32{coef_b_r[31]}}, coef_b_r}) *
                  $signed({{32{s3_ctx_r.dq[DQ_W-1]}}, s3_ctx_r.dq});
      s4_ctx_r <= s3_ctx_r;
    end
  end

  // Stage 5: discriminant A^2 + 4 B d in units of 2^-70.
  logic signed [63:0] s5_disc;
  sqrt_work_t         s5_work;
  ctx_t               s5_ctx;
  logic               s5_valid_r;
  sqrt_work_t         s5_work_r;
  ctx_t               s5_ctx_r;

  always_comb begin
    s5_disc        = $signed({6'd0, s4_aa_r, 6'd0}) + s4_bd_r;
    s5_work.rad    = s5_disc;
    s5_work.root   = '0;
    s5_work.rem    = '0;
    s5_ctx         = s4_ctx_r;
    s5_ctx.negdisc = s5_disc[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_work_r <= s5_work;
      s5_ctx_r  <= s5_ctx;
    end
  end

  // Square root chain: one root bit per cell.
  logic [SQRT_CELLS:0] sq_v;
  sqrt_work_t          sq_w [SQRT_CELLS+1];
  ctx_t                sq_c [SQRT_CELLS+1];

  assign sq_v[0] = s5_valid_r;
  assign sq_w[0] = s5_work_r;
  assign sq_c[0] = s5_ctx_r;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    rtdct_sqrt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (sq_v[i]),
      .in_work     (sq_w[i]),
      .in_ctx      (sq_c[i]),
      .out_valid_r (sq_v[i+1]),
      .out_work_r  (sq_w[i+1]),
      .out_ctx_r   (sq_c[i+1])
    );
  end

  // Stage 6: set up the final division. A positive excess divides by the
  // root plus 8A, a negative one by A alone (the linear form).
  logic [DIV_DEN_W-1:0] s6_den;
  logic [DQ_W-1:0]      s6_dqm;
  logic                 s6_pos;
  div_work_t            s6_work;
  ctx_t                 s6_ctx;
  logic                 s6_valid_r;
  div_work_t            s6_work_r;
  ctx_t                 s6_ctx_r;

  always_comb begin
    s6_ctx         = sq_c[SQRT_CELLS];
    s6_den         = {1'b0, sq_w[SQRT_CELLS].root} + {4'd0, coef_a_r, 3'd0};
    s6_dqm         = s6_ctx.dq[DQ_W-1] ? (~s6_ctx.dq + DQ_W'(1)) : s6_ctx.dq;
    s6_pos         = !s6_ctx.dq[DQ_W-1] && (s6_ctx.dq != '0);
    s6_ctx.dq_zero = (s6_ctx.dq == '0);
    s6_ctx.posinf  = s6_pos && (s6_den == '0);
    s6_ctx.neginf  = s6_ctx.dq[DQ_W-1] && (coef_a_r == 26'd0);
    s6_work.quo    = '0;
    s6_work.rem    = '0;
    if (s6_pos) begin
      s6_work.num = DIV_NUM_W'(s6_dqm) * DIV_NUM_W'(K_POS);
      s6_work.den = s6_den;
    end else begin
      s6_work.num = DIV_NUM_W'(s6_dqm) * DIV_NUM_W'(K_NEG);
      s6_work.den = DIV_DEN_W'(coef_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= sq_v[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_work_r <= s6_work;
      s6_ctx_r  <= s6_ctx;
    end
  end

  // Second divider chain.
  logic [DIV2_CELLS:0] d2_v;
  div_work_t           d2_w [DIV2_CELLS+1];
  ctx_t                d2_c [DIV2_CELLS+1];

  assign d2_v[0] = s6_valid_r;
  assign d2_w[0] = s6_work_r;
  assign d2_c[0] = s6_ctx_r;

  for (genvar i = 0; i < DIV2_CELLS; i++) begin : g_div2
    rtdct_div_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (d2_v[i]),
      .in_work     (d2_w[i]),
      .in_ctx      (d2_c[i]),
      .out_valid_r (d2_v[i+1]),
      .out_work_r  (d2_w[i+1]),
      .out_ctx_r   (d2_c[i+1])
    );
  end

  // Output stage: sign, window check and saturation. The infinite cases
  // from a zero divisor fall below or above any window.
  ctx_t                     fo_ctx;
  logic [RAW_W-1:0]         fo_mag;
  logic signed [RAW_W-1:0]  fo_raw;
  logic signed [RAW_W-1:0]  fo_lo;
  logic signed [RAW_W-1:0]  fo_hi;
  logic                     fo_below;
  logic                     fo_above;
  logic [STAT_W-1:0]        status_nxt;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [TEMP_W-1:0] out_temperature_r;

  always_comb begin
    fo_ctx = d2_c[DIV2_CELLS];
    fo_mag = {2'b00, d2_w[DIV2_CELLS].quo};
    if (fo_ctx.dq_zero) begin
      fo_raw = '0;
    end else if (fo_ctx.dq[DQ_W-1]) begin
      fo_raw = -$signed(fo_mag);
    end else begin
      fo_raw = $signed(fo_mag);
    end
    fo_lo    = {{(RAW_W-TEMP_W){valid_lo_r[TEMP_W-1]}}, valid_lo_r};
    fo_hi    = {{(RAW_W-TEMP_W){valid_hi_r[TEMP_W-1]}}, valid_hi_r};
    fo_below = fo_ctx.neginf || (!fo_ctx.posinf && (fo_raw < fo_lo));
    fo_above = fo_ctx.posinf || (!fo_ctx.neginf && (fo_raw > fo_hi));
  end

  always_comb begin
    status_nxt = (fo_below || fo_above) ? ST_WINDOW : ST_OK;
    priority if (fo_ctx.nomz || fo_ctx.negdisc) begin
      status_nxt = ST_NOROOT;
      temp_nxt   = '0;
    end else if (fo_ctx.neginf) begin
      temp_nxt = TEMP_MIN;
    end else if (fo_ctx.posinf) begin
      temp_nxt = TEMP_MAX;
    end else if (fo_raw < RAW_MIN) begin
      temp_nxt = TEMP_MIN;
    end else if (fo_raw > RAW_MAX) begin
      temp_nxt = TEMP_MAX;
    end else begin
      temp_nxt = fo_raw[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_v[DIV2_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r      <= status_nxt;
      out_temperature_r <= temp_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_temperature = out_temperature_r;

  // A missing root always reports zero degrees.
  a_noroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_NOROOT) |-> out_temperature_r == '0)
    else $error("no-root transaction with nonzero temperature");

  // Reported temperatures stay inside the saturation limits.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_temperature_r >= TEMP_MIN && out_temperature_r <= TEMP_MAX))
    else $error("temperature outside saturation limits");

  // The input side only stalls when its register is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_valid_r)
    else $error("input stalled with an empty input stage");

  // A held pipeline keeps stage 1 intact.
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !en) |=> (s1_valid_r && $stable(s1_n_r)))
    else $error("pipeline moved while held");

endmodule

// ===== verif/rtd_code_to_temperature_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtd_code_to_temperature_test: self-checking bench for the RTD converter
// The bench streams converter codes through the block under several register
// settings and predicts every temperature and status in exact integer math.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature_test;
  import rtdct_pkg::*;

  // Pipeline depth of the block, with a little slack.
  localparam int PIPE_DEPTH  = 140;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint DQ_CEIL  = 64'sd2147483647;
  localparam longint RAW_HUGE = 64'sd4611686018427387904;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CODE_BITS-1:0]     in_rtd_code;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [TEMP_W-1:0] out_temperature;
  logic [STAT_W-1:0]        out_status;
  logic                     cfg_we;
  logic [IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;

  int mismatch_count = 0;
  int cycle_count = 0;

  rtd_code_to_temperature dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rtd_code(in_rtd_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temperature(out_temperature), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Every mismatch goes through here so the final verdict sees it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic [STAT_W-1:0]        status;
  } reading_t;

  // Scoreboard: it keeps its own copy of the registers, converts each
  // accepted code into the expected reading, and holds readings in order.
  class reading_scoreboard;
    logic [15:0]        ref_res;
    logic [15:0]        nom_res;
    logic [25:0]        coef_a;
    logic signed [31:0] coef_b;
    logic signed [18:0] valid_lo;
    logic signed [18:0] valid_hi;
    reading_t           pending[$];

    function new();
      ref_res  = 16'd3440;
      nom_res  = 16'd800;
      coef_a   = 26'd16786021;
      coef_b   = -32'sd162551799;
      valid_lo = -19'sd20000;
      valid_hi = 19'sd85000;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_REF_RES:  ref_res  = val[15:0];
        CFG_NOM_RES:  nom_res  = val[15:0];
        CFG_COEF_A:   coef_a   = val[25:0];
        CFG_COEF_B:   coef_b   = val[31:0];
        CFG_VALID_LO: valid_lo = val[18:0];
        CFG_VALID_HI: valid_hi = val[18:0];
        default: ;
      endcase
    endfunction

    // Bitwise floor square root of a 64-bit radicand.
    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] cand;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        cand = r | (64'd1 << i);
        if (cand * cand <= v) r = cand;
      end
      return r;
    endfunction

    function reading_t convert(logic [CODE_BITS-1:0] code);
      reading_t     rd;
      longint       n, d, dq, disc, raw;
      logic [63:0]  den;
      rd.temperature = '0;
      rd.status      = ST_NOROOT;
      // A zero nominal resistance has no relative excess at all.
      if (nom_res == 0) return rd;
      n  = longint'(code) * longint'(ref_res);
      d  = longint'(nom_res) << 15;
      dq = ((n - d) * 64'sd16777216) / d;
      if (dq > DQ_CEIL) dq = DQ_CEIL;
      disc = longint'(coef_a) * longint'(coef_a) * 64 + longint'(coef_b) * dq;
      if (disc < 0) return rd;
      if (dq < 0) begin
        // Below the nominal point the linear form applies.
        raw = (coef_a == 0) ? -RAW_HUGE : (dq * 64'sd25600) / longint'(coef_a);
      end else if (dq == 0) begin
        raw = 0;
      end else begin
        den = floor_sqrt(disc) + 64'd8 * coef_a;
        raw = (den == 0) ? RAW_HUGE : (dq * 64'sd409600) / longint'(den);
      end
      // The window is judged before saturation; an empty window flags all.
      rd.status = (raw < longint'(valid_lo) || raw > longint'(valid_hi)) ?
                  ST_WINDOW : ST_OK;
      if (raw < T_MIN) raw = T_MIN;
      if (raw > T_MAX) raw = T_MAX;
      rd.temperature = raw[TEMP_W-1:0];
      return rd;
    endfunction

    function void note_code(logic [CODE_BITS-1:0] code);
      pending.push_back(convert(code));
    endfunction

    task check_reading(logic signed [TEMP_W-1:0] t, logic [STAT_W-1:0] st);
      reading_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected reading temp=%0d status=%0d", t, st));
        return;
      end
      want = pending.pop_front();
      if (t !== want.temperature)
        report_mismatch($sformatf("temperature %0d, expected %0d",
                                  t, want.temperature));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
    endtask
  endclass

  reading_scoreboard sb = new();

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rtd_code_to_temperature_test NOT OK");
      $finish;
    end
  end

  // Receiver stall pattern: the mode switches at random between no
  // stall, scattered stalls and long stall runs.
  int stall_mode = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: begin
        if (stall_run > 0) begin
          stall_run <= stall_run - 1;
          out_stall <= 1'b1;
        end else begin
          stall_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : 0;
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  // Result monitor: a transaction completes at an edge with valid and no stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reading(out_temperature, out_status);
  end

  // Register writes happen only while the pipeline is empty; the scoreboard
  // copy is updated as the write is driven, before the block takes it.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] r, input logic [15:0] nm,
                              input logic [25:0] a, input logic signed [31:0] b,
                              input int lo, input int hi);
    write_reg(CFG_REF_RES, {16'd0, r});
    write_reg(CFG_NOM_RES, {16'd0, nm});
    write_reg(CFG_COEF_A, {6'd0, a});
    write_reg(CFG_COEF_B, b);
    write_reg(CFG_VALID_LO, lo);
    write_reg(CFG_VALID_HI, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender burst bookkeeping: in_valid stays high inside a burst and drops
  // for a random gap between most bursts.
  int burst_left = 0;

  task automatic send_code(input logic [CODE_BITS-1:0] code);
    in_valid    <= 1'b1;
    in_rtd_code <= code;
    do @(posedge clk); while (in_stall);
    sb.note_code(code);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Drain: wait for every reading, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Random codes: half uniform, half clustered around the code where the
  // probe sits at its nominal resistance, so both branches are well used.
  task automatic random_codes(input int count);
    longint centre;
    int     c;
    centre = (sb.ref_res == 0) ? 0 :
             (longint'(sb.nom_res) * 32768) / longint'(sb.ref_res);
    if (centre > 32767) centre = 32767;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        c = $urandom_range(0, 32767);
      end else begin
        c = int'(centre) + $urandom_range(0, 4000) - 2000;
        if (c < 0) c = 0;
        if (c > 32767) c = 32767;
      end
      send_code(c[CODE_BITS-1:0]);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rtd_code = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: field extremes, the nominal point neighborhood, and
    // codes far above and below the window.
    send_code(15'd0);
    send_code(15'd32767);
    send_code(15'd1);
    send_code(15'd16384);
    send_code(15'd7620);
    send_code(15'd7621);
    send_code(15'd5000);
    send_code(15'd12000);
    send_code(15'h2AAA);
    send_code(15'h5555);
    random_codes(220);
    drain();

    // Extreme registers: the excess saturates and big codes lose the root.
    load_setting(16'hFFFF, 16'd1, 26'h3FFFFFF, 32'sh80000000, -100000, 200000);
    send_code(15'd0);
    send_code(15'd1);
    send_code(15'd32767);
    random_codes(80);
    drain();

    // Reference twice the nominal: code 16384 lands exactly on zero excess.
    load_setting(16'd2, 16'd1, 26'd16786021, -32'sd162551799, -1000, 1000);
    send_code(15'd16384);
    send_code(15'd16383);
    send_code(15'd16385);
    random_codes(80);
    drain();

    // Zero nominal resistance: every code reports no real root.
    load_setting(16'd3440, 16'd0, 26'd16786021, -32'sd162551799, -20000, 85000);
    send_code(15'd0);
    send_code(15'd32767);
    random_codes(20);
    drain();

    // Zero A and B with an empty window: infinities on both sides, all flagged.
    load_setting(16'd3440, 16'd800, 26'd0, 32'sd0, 200000, -100000);
    send_code(15'd0);
    send_code(15'd32767);
    random_codes(60);
    drain();

    // Smallest reference, largest nominal, tiny coefficients.
    load_setting(16'd1, 16'hFFFF, 26'd1, -32'sd1, -100000, 200000);
    send_code(15'd0);
    send_code(15'd32767);
    random_codes(40);
    drain();

    // A realistic sensor with a narrow window, then plain random registers.
    load_setting(16'd3440, 16'd800, 26'd16786021, -32'sd162551799, 0, 10000);
    random_codes(120);
    drain();
    load_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 26'($urandom_range(1, 67108863)), -$urandom_range(1, 400000000),
                 -$urandom_range(0, 100000), $urandom_range(0, 200000));
    random_codes(80);
    drain();

    if (mismatch_count == 0)
      $display("rtd_code_to_temperature_test OK");
    else
      $display("rtd_code_to_temperature_test NOT OK");
    $finish;
  end

endmodule
